// File: rtl/core/wbca_pkg.sv
// Package for the write-budget cache admission unit.
// Holds field widths, reset values, codes and the sequencer state type.
// No dependencies.
package wbca_pkg;

  localparam int ENTRIES_DEF = 1024;
  localparam int ID_W        = 32;
  localparam int SIZE_W      = 40;
  localparam int HITS_W      = 4;
  localparam int HELD_W      = 41;
  localparam int WR_W        = 48;
  localparam int THR_W       = 3;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 64;

  localparam logic [SIZE_W-1:0] CAPACITY_RST = 40'd214748364800;
  localparam logic [SIZE_W-1:0] WQUOTA_RST   = 40'd3221225472;
  localparam logic [SIZE_W-1:0] PQUOTA_RST   = 40'd104857600;

  typedef enum logic [1:0] {
    KIND_PLAIN  = 2'd0,
    KIND_FILTER = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam logic [THR_W-1:0] THR_ONE     = 3'd1;
  localparam logic [THR_W-1:0] THR_TWO     = 3'd2;
  localparam logic [THR_W-1:0] THR_THREE   = 3'd3;
  localparam logic [THR_W-1:0] THR_BLOCKED = 3'd7;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_WQUOTA   = 2'd1;
  localparam logic [1:0] REG_PQUOTA   = 2'd2;

  localparam logic [HITS_W-1:0] HITS_MAX = 4'd15;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_TICK, ST_ADD, ST_THR,
    ST_S_RD, ST_S_CHK,
    ST_H_UP, ST_H_UPW, ST_H_UN, ST_H_UNW, ST_H_PT, ST_H_PTW, ST_H_WE,
    ST_EV_CHK, ST_EV_RD, ST_EV_WR, ST_EV_NRD, ST_EV_NWR,
    ST_F_RD, ST_F_CHK,
    ST_I_PT, ST_I_PTW, ST_I_WE,
    ST_DONE
  } state_t;

endpackage

// File: rtl/core/wbca_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module wbca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/write_budget_cache_admission_unit.sv
// Top level of the write-budget cache admission unit: sequencer, ghost table
// control and APB register file. Depends on wbca_pkg and wbca_ram.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    kind, object_id, object_size, size_present
//   out      out  out_valid/out_ready  admit
//   cfg      in   APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// Sequencing: a filtered request scans the ghost table memory entry by entry;
// a hit relinks the entry at the tail of the recency list, and a miss scans
// the whole table, evicts the oldest entries as needed and searches for a free
// slot. The table memory has a single port. After reset a clearing pass over
// every table entry runs before the first beat is taken. Results sit in an
// output register, so a new beat is taken while a finished result still waits
// for out_ready.
module write_budget_cache_admission_unit
  import wbca_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [ID_W-1:0]   object_id,
  input  logic [SIZE_W-1:0] object_size,
  input  logic              size_present,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              admit,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = IW + 1;
  localparam logic [LW-1:0] NIL  = LW'(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  // One table word: the entry itself plus both recency links (NIL ends a list).
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic [HITS_W-1:0] hits;
    logic [LW-1:0]     next;
    logic [LW-1:0]     prev;
  } ent_t;

  localparam int EW = $bits(ent_t);

  state_t state, state_next;

  logic [IW-1:0]     idx, idx_next;
  logic [IW-1:0]     fidx, fidx_next;
  logic [LW-1:0]     nbr, nbr_next;
  logic [1:0]        kind_q, kind_q_next;
  logic [ID_W-1:0]   id_q, id_q_next;
  logic [SIZE_W-1:0] size_q, size_q_next;
  logic [SIZE_W-1:0] cap, wq, pq;
  logic [LW-1:0]     head, head_next, tail, tail_next, count, count_next;
  logic [HELD_W-1:0] held, held_next;
  logic [WR_W-1:0]   written, written_next;
  logic [THR_W-1:0]  thr, thr_next;
  ent_t              cur, cur_next;
  logic              adm, adm_next;
  logic              res_valid, res_valid_next, res_admit, res_admit_next;

  logic              we;
  logic [IW-1:0]     waddr, raddr;
  ent_t              wdata, rd;
  logic [EW-1:0]     rdata_raw;

  logic              cfg_wr;
  logic              match;
  logic              over_cap;
  logic [WR_W:0]     wsum;
  logic [WR_W-1:0]   q1, q2, q3;

  wbca_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rd       = rdata_raw;
  assign in_ready = (state == ST_IDLE);
  assign out_valid = res_valid;
  assign admit     = res_admit;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  assign match    = rd.valid && (rd.id == id_q) && (rd.size == size_q);
  // Does the held total plus the new object exceed the capacity?
  assign over_cap = ({1'b0, held} + (HELD_W+1)'(size_q)) > (HELD_W+1)'(cap);
  assign wsum     = {1'b0, written} + (WR_W+1)'(size_q);
  assign q1       = WR_W'(wq);
  assign q2       = WR_W'({wq, 1'b0});
  assign q3       = q1 + q2;

  always_comb begin
    case (paddr[4:3])
      REG_CAPACITY: prdata = APB_DW'(cap);
      REG_WQUOTA:   prdata = APB_DW'(wq);
      REG_PQUOTA:   prdata = APB_DW'(pq);
      default:      prdata = '0;
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (idx == LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_TICK) state_next = ST_TICK;
          else if (kind == KIND_NONE) state_next = ST_IDLE;
          else if (!size_present) state_next = ST_DONE;
          else if (kind == KIND_PLAIN) state_next = ST_ADD;
          else if (thr == THR_BLOCKED) state_next = ST_DONE;
          else state_next = ST_S_RD;
        end
      end
      ST_TICK: state_next = ST_IDLE;
      ST_ADD:  state_next = (kind_q == KIND_FILTER) ? ST_THR : ST_DONE;
      ST_THR:  state_next = ST_DONE;
      ST_S_RD: state_next = ST_S_CHK;
      ST_S_CHK: begin
        if (match) state_next = ST_H_UP;
        else if (idx == LAST) state_next = (size_q > cap) ? ST_DONE : ST_EV_CHK;
        else state_next = ST_S_RD;
      end
      ST_H_UP:  state_next = (cur.prev == NIL) ? ST_H_UN : ST_H_UPW;
      ST_H_UPW: state_next = ST_H_UN;
      ST_H_UN:  state_next = (cur.next == NIL) ? ST_H_PT : ST_H_UNW;
      ST_H_UNW: state_next = ST_H_PT;
      ST_H_PT:  state_next = (tail == NIL) ? ST_H_WE : ST_H_PTW;
      ST_H_PTW: state_next = ST_H_WE;
      ST_H_WE:  state_next = (cur.hits > {1'b0, thr}) ? ST_ADD : ST_DONE;
      ST_EV_CHK: begin
        if ((over_cap && head != NIL) || count >= NIL) state_next = ST_EV_RD;
        else state_next = ST_F_RD;
      end
      ST_EV_RD:  state_next = ST_EV_WR;
      ST_EV_WR:  state_next = (rd.next == NIL) ? ST_EV_CHK : ST_EV_NRD;
      ST_EV_NRD: state_next = ST_EV_NWR;
      ST_EV_NWR: state_next = ST_EV_CHK;
      ST_F_RD:   state_next = ST_F_CHK;
      ST_F_CHK: begin
        if (!rd.valid) state_next = ST_I_PT;
        else if (idx == LAST) state_next = ST_DONE;
        else state_next = ST_F_RD;
      end
      ST_I_PT:  state_next = (tail == NIL) ? ST_I_WE : ST_I_PTW;
      ST_I_PTW: state_next = ST_I_WE;
      ST_I_WE:  state_next = ST_DONE;
      ST_DONE:  if (!res_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory control and register updates for each state.
  always_comb begin
    idx_next       = idx;
    fidx_next      = fidx;
    nbr_next       = nbr;
    kind_q_next    = kind_q;
    id_q_next      = id_q;
    size_q_next    = size_q;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    held_next      = held;
    written_next   = written;
    thr_next       = thr;
    cur_next       = cur;
    adm_next       = adm;
    res_valid_next = res_valid && !out_ready;
    res_admit_next = res_admit;
    we             = 1'b0;
    waddr          = idx;
    wdata          = rd;
    raddr          = idx;
    unique case (state)
      ST_CLEAR: begin
        we       = 1'b1;
        wdata    = '0;
        idx_next = idx + 1'b1;
      end
      ST_IDLE: begin
        if (in_valid) begin
          kind_q_next = kind;
          id_q_next   = object_id;
          size_q_next = object_size;
          idx_next    = '0;
          adm_next    = 1'b0;
        end
      end
      ST_TICK: begin
        if (written > WR_W'(pq)) begin
          thr_next     = THR_BLOCKED;
          written_next = written - WR_W'(pq);
        end else begin
          thr_next     = THR_ONE;
          written_next = '0;
        end
      end
      ST_ADD: begin
        written_next = wsum[WR_W] ? '1 : wsum[WR_W-1:0];
        adm_next     = 1'b1;
      end
      ST_THR: begin
        if (written > q1 && written < q2) thr_next = THR_TWO;
        else if (written >= q2 && written < q3) thr_next = THR_THREE;
        else if (written >= q3) thr_next = THR_BLOCKED;
      end
      ST_S_RD: raddr = idx;
      ST_S_CHK: begin
        if (match) begin
          cur_next = rd;
          if (rd.hits != HITS_MAX) cur_next.hits = rd.hits + 1'b1;
          fidx_next = idx;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_H_UP: begin
        if (cur.prev == NIL) head_next = cur.next;
        else raddr = cur.prev[IW-1:0];
      end
      ST_H_UPW: begin
        we         = 1'b1;
        waddr      = cur.prev[IW-1:0];
        wdata.next = cur.next;
      end
      ST_H_UN: begin
        if (cur.next == NIL) tail_next = cur.prev;
        else raddr = cur.next[IW-1:0];
      end
      ST_H_UNW: begin
        we         = 1'b1;
        waddr      = cur.next[IW-1:0];
        wdata.prev = cur.prev;
      end
      ST_H_PT: begin
        if (tail == NIL) head_next = {1'b0, fidx};
        else raddr = tail[IW-1:0];
      end
      ST_H_PTW: begin
        we         = 1'b1;
        waddr      = tail[IW-1:0];
        wdata.next = {1'b0, fidx};
      end
      ST_H_WE: begin
        we         = 1'b1;
        waddr      = fidx;
        wdata      = cur;
        wdata.prev = tail;
        wdata.next = NIL;
        tail_next  = {1'b0, fidx};
      end
      ST_EV_CHK: idx_next = '0;
      ST_EV_RD:  raddr = head[IW-1:0];
      ST_EV_WR: begin
        // Drop the oldest entry; its successor becomes the new head.
        we          = 1'b1;
        waddr       = head[IW-1:0];
        wdata.valid = 1'b0;
        head_next   = rd.next;
        held_next   = held - HELD_W'(rd.size);
        count_next  = count - 1'b1;
        nbr_next    = rd.next;
        if (rd.next == NIL) tail_next = NIL;
      end
      ST_EV_NRD: raddr = nbr[IW-1:0];
      ST_EV_NWR: begin
        we         = 1'b1;
        waddr      = nbr[IW-1:0];
        wdata.prev = NIL;
      end
      ST_F_RD: raddr = idx;
      ST_F_CHK: begin
        if (!rd.valid) fidx_next = idx;
        else idx_next = idx + 1'b1;
      end
      ST_I_PT: begin
        if (tail == NIL) head_next = {1'b0, fidx};
        else raddr = tail[IW-1:0];
      end
      ST_I_PTW: begin
        we         = 1'b1;
        waddr      = tail[IW-1:0];
        wdata.next = {1'b0, fidx};
      end
      ST_I_WE: begin
        we          = 1'b1;
        waddr       = fidx;
        wdata.valid = 1'b1;
        wdata.id    = id_q;
        wdata.size  = size_q;
        wdata.hits  = HITS_W'(1);
        wdata.next  = NIL;
        wdata.prev  = tail;
        tail_next   = {1'b0, fidx};
        held_next   = held + HELD_W'(size_q);
        count_next  = count + 1'b1;
      end
      ST_DONE: begin
        if (!res_valid || out_ready) begin
          res_valid_next = 1'b1;
          res_admit_next = adm;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      head      <= NIL;
      tail      <= NIL;
      count     <= '0;
      held      <= '0;
      written   <= '0;
      thr       <= THR_ONE;
      res_valid <= 1'b0;
      cap       <= CAPACITY_RST;
      wq        <= WQUOTA_RST;
      pq        <= PQUOTA_RST;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      held      <= held_next;
      written   <= written_next;
      thr       <= thr_next;
      res_valid <= res_valid_next;
      if (cfg_wr) begin
        case (paddr[4:3])
          REG_CAPACITY: cap <= pwdata[SIZE_W-1:0];
          REG_WQUOTA:   wq  <= pwdata[SIZE_W-1:0];
          REG_PQUOTA:   pq  <= pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    fidx      <= fidx_next;
    nbr       <= nbr_next;
    kind_q    <= kind_q_next;
    id_q      <= id_q_next;
    size_q    <= size_q_next;
    cur       <= cur_next;
    adm       <= adm_next;
    res_admit <= res_admit_next;
  end

endmodule

// File: tb/sv/tb_write_budget_cache_admission_unit.sv
// Self-checking testbench for write_budget_cache_admission_unit.
// It holds its own ghost-table predictor and drives both channels and the APB port.
// It depends on wbca_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_write_budget_cache_admission_unit;
  import wbca_pkg::*;

  localparam longint unsigned MAX40 = 64'hFF_FFFF_FFFF;
  localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;
  localparam int NIL = ENTRIES_DEF;

  // One request beat as the sender presents it.
  typedef struct {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic              present;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = KIND_PLAIN;
  logic [ID_W-1:0] object_id = '0;
  logic [SIZE_W-1:0] object_size = '0;
  logic size_present = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic admit;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  write_budget_cache_admission_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .object_id(object_id), .object_size(object_size),
    .size_present(size_present),
    .out_valid(out_valid), .out_ready(out_ready), .admit(admit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the unit's state. The recency list runs from ghost_head
  // (least recent) to ghost_tail (most recent).
  logic                ghost_valid [ENTRIES_DEF];
  logic [ID_W-1:0]     ghost_id    [ENTRIES_DEF];
  logic [SIZE_W-1:0]   ghost_size  [ENTRIES_DEF];
  int                  ghost_hits  [ENTRIES_DEF];
  int                  ghost_next  [ENTRIES_DEF];
  int                  ghost_prev  [ENTRIES_DEF];
  int                  ghost_head, ghost_tail, ghost_count;
  longint unsigned     held_total, written_total;
  logic [THR_W-1:0]    threshold;
  longint unsigned     cap_reg, wquota_reg, pquota_reg;

  request_t        pending_q[$];
  logic            admit_q[$];
  int              mismatches = 0;
  int              beats_taken = 0;
  int              results_seen = 0;
  int              hits_admitted = 0;
  int              table_evictions = 0;
  longint unsigned cyc = 0;
  logic            calm;

  // Idling stops altogether for one window in every six.
  always @(posedge clk) cyc <= cyc + 1;
  assign calm = ((cyc / 3000) % 6) == 5;

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic unlink_entry(input int i);
    int p, n;
    p = ghost_prev[i];
    n = ghost_next[i];
    if (p == NIL) ghost_head = n; else ghost_next[p] = n;
    if (n == NIL) ghost_tail = p; else ghost_prev[n] = p;
  endtask

  task automatic append_entry(input int i);
    ghost_prev[i] = ghost_tail;
    ghost_next[i] = NIL;
    if (ghost_tail == NIL) ghost_head = i; else ghost_next[ghost_tail] = i;
    ghost_tail = i;
  endtask

  task automatic drop_oldest();
    int i;
    i = ghost_head;
    if (i == NIL) return;
    unlink_entry(i);
    held_total -= ghost_size[i];
    ghost_valid[i] = 1'b0;
    ghost_count--;
    table_evictions++;
  endtask

  task automatic count_written(input longint unsigned sz);
    written_total += sz;
    if (written_total > MAX48) written_total = MAX48;
  endtask

  // Works out the admission decision for one accepted beat and updates the
  // shadow state. Ticks and the unused kind leave no result behind.
  task automatic predict_admission(input request_t r);
    int found, slot;
    longint unsigned sz;
    found = NIL;
    slot = NIL;
    sz = r.size;
    if (r.kind == KIND_TICK) begin
      if (written_total > pquota_reg) begin
        threshold = THR_BLOCKED;
        written_total -= pquota_reg;
      end else begin
        threshold = THR_ONE;
        written_total = 0;
      end
      return;
    end
    if (r.kind == KIND_NONE) return;
    if (!r.present) begin
      admit_q.push_back(1'b0);
      return;
    end
    if (r.kind == KIND_PLAIN) begin
      count_written(sz);
      admit_q.push_back(1'b1);
      return;
    end
    if (threshold == THR_BLOCKED) begin
      admit_q.push_back(1'b0);
      return;
    end
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      if (ghost_valid[i] && ghost_id[i] == r.id && ghost_size[i] == r.size) begin
        found = i;
        break;
      end
    end
    if (found != NIL) begin
      if (ghost_hits[found] < HITS_MAX) ghost_hits[found]++;
      unlink_entry(found);
      append_entry(found);
      if (ghost_hits[found] <= threshold) begin
        admit_q.push_back(1'b0);
        return;
      end
      count_written(sz);
      // The threshold only ever rises here; the tick sets it to one or to blocked.
      if (written_total > wquota_reg && written_total < 2 * wquota_reg)
        threshold = THR_TWO;
      else if (written_total >= 2 * wquota_reg && written_total < 3 * wquota_reg)
        threshold = THR_THREE;
      else if (written_total >= 3 * wquota_reg)
        threshold = THR_BLOCKED;
      hits_admitted++;
      admit_q.push_back(1'b1);
      return;
    end
    if (sz > cap_reg) begin
      admit_q.push_back(1'b0);
      return;
    end
    while (held_total + sz > cap_reg && ghost_head != NIL) drop_oldest();
    if (ghost_count >= ENTRIES_DEF) drop_oldest();
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      if (!ghost_valid[i]) begin
        slot = i;
        break;
      end
    end
    if (slot != NIL) begin
      ghost_valid[slot] = 1'b1;
      ghost_id[slot] = r.id;
      ghost_size[slot] = r.size;
      ghost_hits[slot] = 1;
      append_entry(slot);
      held_total += sz;
      ghost_count++;
    end
    admit_q.push_back(1'b0);
  endtask

  // Sender: a new beat is offered only once the previous one has gone.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_admission('{kind_t'(kind), object_id, object_size, size_present});
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
          request_t r;
          r = pending_q.pop_front();
          in_valid <= 1'b1;
          kind <= r.kind;
          object_id <= r.id;
          object_size <= r.size;
          size_present <= r.present;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, and each result beat is checked against
  // the oldest expected decision.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 17);
      if (out_valid && out_ready) begin
        results_seen++;
        if (admit_q.size() == 0)
          report($sformatf("result beat admit=%0b with nothing expected", admit));
        else if (admit !== admit_q[0]) begin
          report($sformatf("admit=%0b, expected %0b", admit, admit_q[0]));
          void'(admit_q.pop_front());
        end else
          void'(admit_q.pop_front());
      end
    end
  end

  // Waits until every queued beat has been taken and answered, then lets the
  // unit finish any tick that is still in flight.
  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() > 0 || in_valid || admit_q.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  // APB write: setup cycle, then an access cycle; the register takes the
  // value at the edge that closes the access cycle.
  task automatic write_reg(input logic [1:0] idx, input longint unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_CAPACITY: cap_reg = value & MAX40;
      REG_WQUOTA:   wquota_reg = value & MAX40;
      default:      pquota_reg = value & MAX40;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input longint unsigned cap, input longint unsigned wq,
                            input longint unsigned pq);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_WQUOTA, wq);
    write_reg(REG_PQUOTA, pq);
  endtask

  task automatic push(input kind_t k, input logic [ID_W-1:0] id,
                      input logic [SIZE_W-1:0] sz, input logic present);
    pending_q.push_back('{k, id, sz, present});
  endtask

  // Sets a generous period quota and ticks, so that the write counter drops by
  // that quota and the threshold returns to one unless the counter still exceeded it.
  task automatic relax();
    drain();
    write_reg(REG_PQUOTA, MAX40);
    push(KIND_TICK, $urandom, SIZE_W'({$urandom, $urandom}), 1'($urandom));
    drain();
  endtask

  // Mostly well-formed requests over a small pool of objects so that hits,
  // threshold steps and evictions all occur, with ticks and some noise.
  task automatic random_pool(input int n, input int ids, input int sizes,
                             input int size_step, input int oversize);
    int pick;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(99);
      if (pick < 8)
        push(KIND_TICK, $urandom, SIZE_W'({$urandom, $urandom}), 1'($urandom));
      else if (pick < 11)
        push(KIND_NONE, $urandom, SIZE_W'({$urandom, $urandom}), 1'($urandom));
      else if (pick < 16)
        push(kind_t'($urandom_range(1)), $urandom, SIZE_W'({$urandom, $urandom}), 1'b0);
      else if (pick < 20)
        push(KIND_FILTER, $urandom_range(ids - 1), SIZE_W'(oversize), 1'b1);
      else if (pick < 30)
        push(KIND_PLAIN, $urandom, SIZE_W'($urandom_range(sizes - 1) * size_step), 1'b1);
      else
        push(KIND_FILTER, 32'h8000_0000 | $urandom_range(ids - 1),
             SIZE_W'($urandom_range(sizes - 1) * size_step), 1'b1);
    end
  endtask

  task automatic table_fill(input int n);
    logic [ID_W-1:0] recent_id[$];
    logic [SIZE_W-1:0] recent_sz[$];
    logic [ID_W-1:0] id;
    logic [SIZE_W-1:0] sz;
    int pick, k;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(99);
      if (pick < 4 && recent_id.size() > 0) begin
        k = $urandom_range(recent_id.size() - 1);
        push(KIND_FILTER, recent_id[k], recent_sz[k], 1'b1);
      end else if (pick < 6) begin
        push(KIND_PLAIN, $urandom, SIZE_W'($urandom_range(1000)), 1'b1);
      end else begin
        id = $urandom;
        sz = SIZE_W'($urandom_range(1000));
        push(KIND_FILTER, id, sz, 1'b1);
        recent_id.push_back(id);
        recent_sz.push_back(sz);
        if (recent_id.size() > 16) begin
          void'(recent_id.pop_front());
          void'(recent_sz.pop_front());
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES_DEF; i++) ghost_valid[i] = 1'b0;
    ghost_head = NIL;
    ghost_tail = NIL;
    ghost_count = 0;
    held_total = 0;
    written_total = 0;
    threshold = THR_ONE;
    cap_reg = 64'(CAPACITY_RST);
    wquota_reg = 64'(WQUOTA_RST);
    pquota_reg = 64'(PQUOTA_RST);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the reset settings: missing size on both request
    // kinds, plain requests at the size extremes, a miss then hits, an object
    // above the capacity, ticks while the threshold stays blocked, and
    // the unused kind.
    push(KIND_PLAIN, 32'h0, 40'h0, 1'b1);
    push(KIND_PLAIN, 32'hFFFF_FFFF, SIZE_W'(MAX40), 1'b1);
    push(KIND_PLAIN, 32'h1234, 40'd10, 1'b0);
    push(KIND_FILTER, 32'h1234, 40'd10, 1'b0);
    push(KIND_FILTER, 32'h0000_0007, 40'd100, 1'b1);
    push(KIND_FILTER, 32'h0000_0007, 40'd100, 1'b1);
    push(KIND_FILTER, 32'h0000_0007, 40'd100, 1'b1);
    push(KIND_FILTER, 32'h0000_0007, 40'd101, 1'b1);
    push(KIND_FILTER, 32'hFFFF_FFFF, SIZE_W'(MAX40), 1'b1);
    push(KIND_FILTER, 32'hFFFF_FFFF, 40'd214748364800, 1'b1);
    push(KIND_FILTER, 32'hFFFF_FFFF, 40'd214748364800, 1'b1);
    push(KIND_FILTER, 32'hFFFF_FFFF, 40'd214748364800, 1'b1);
    push(KIND_NONE, 32'hFFFF_FFFF, SIZE_W'(MAX40), 1'b1);
    push(KIND_TICK, 32'h0, 40'h0, 1'b0);
    push(KIND_FILTER, 32'h0000_0007, 40'd100, 1'b1);
    push(KIND_PLAIN, 32'hA5A5_5A5A, 40'hAA_AAAA_AAAA, 1'b1);
    push(KIND_TICK, 32'hFFFF_FFFF, SIZE_W'(MAX40), 1'b1);
    push(KIND_FILTER, 32'h0000_0007, 40'd100, 1'b1);
    // The sender holds off here until every decision has come back.
    drain();

    // Small capacity and small quotas; the threshold stays blocked from the
    // directed beats, so every filtered request with a size is refused.
    relax();
    set_config(64'd1000, 64'd3000, 64'd2000);
    random_pool(80, 6, 4, 130, 1200);
    drain();

    // Zero capacity and zero quotas: only empty objects fit the table.
    relax();
    set_config(64'd0, 64'd0, 64'd0);
    random_pool(30, 3, 2, 1, 1);
    drain();

    // Largest settings: fill the table past its entry count so that the
    // full-table eviction runs, then saturate the write counter.
    relax();
    set_config(MAX40, MAX40, MAX40);
    table_fill(1100);
    for (int j = 0; j < 260; j++) push(KIND_PLAIN, $urandom, SIZE_W'(MAX40), 1'b1);
    push(KIND_TICK, 32'h0, 40'h0, 1'b0);
    push(KIND_FILTER, 32'h5, 40'd5, 1'b1);
    drain();
    repeat (50) @(posedge clk);

    $display("Covered %0d request beats and %0d decisions across four register settings;",
             beats_taken, results_seen);
    $display("%0d admissions on hits and %0d ghost-table evictions were predicted.",
             hits_admitted, table_evictions);
    if (mismatches == 0) begin
      $display("tb_write_budget_cache_admission_unit passed");
    end else begin
      $display("tb_write_budget_cache_admission_unit failed");
    end
    $finish;
  end

  // A filtered miss costs a full table scan plus evictions, so the bound is
  // set from that worst case over every beat, with a wide margin.
  initial begin
    #1_000_000_000;
    $display("Timed out with %0d decisions still expected.", admit_q.size());
    $display("tb_write_budget_cache_admission_unit failed");
    $finish;
  end

endmodule
